### rtl/core/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/mbps_pkg.sv
`timescale 1ns / 1ps
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int WIN_DEPTH         = MAX_PATTERN_BYTES - 1;
  localparam int FILL_W            = $clog2(MAX_PATTERN_BYTES);
  localparam int LEN_W             = 5;
  localparam int BYTE_W            = 8;
  localparam int ADDR_W            = 48;
  localparam int CFG_INDEX_W       = 8;
  localparam int CFG_DATA_W        = 64;
  localparam int IN_TDATA_W        = 56;
  localparam int OUT_TDATA_W       = 48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 8'd0,
    REG_PATTERN_LOW    = 8'd1,
    REG_PATTERN_HIGH   = 8'd2,
    REG_CARE_MASK      = 8'd3
  } mbps_reg_t;

  typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] mbps_pat_t;
  typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0]         mbps_win_t;

  typedef struct packed {
    logic [LEN_W-1:0]             length;
    mbps_pat_t                    bytes;
    logic [MAX_PATTERN_BYTES-1:0] care;
  } mbps_cfg_t;

  typedef struct packed {
    logic             hit;
    logic [FILL_W-1:0] offset;   // pattern length - 1, back to the first byte
  } mbps_hit_t;

endpackage

### rtl/core/mbps_match.sv
`timescale 1ns / 1ps
module mbps_match (
  input  mbps_pkg::mbps_cfg_t                 cfg,
  input  logic [mbps_pkg::BYTE_W-1:0]         cur_byte,
  input  mbps_pkg::mbps_win_t                 window,
  input  logic [mbps_pkg::FILL_W-1:0]         fill,
  output mbps_pkg::mbps_hit_t                 result
);
  import mbps_pkg::*;

  logic [LEN_W-1:0]             len_c;
  logic [MAX_PATTERN_BYTES-1:0] mismatch;
  logic                         enough;

  assign len_c = (cfg.length > LEN_W'(MAX_PATTERN_BYTES)) ? LEN_W'(MAX_PATTERN_BYTES)
                                                          : cfg.length;
  assign enough = (({1'b0, fill} + LEN_W'(1)) >= len_c);

  // Position b counts back from the current byte; it meets pattern byte len-1-b.
  always_comb begin
    logic [LEN_W-1:0]  j;
    logic [BYTE_W-1:0] seen;
    for (int b = 0; b < MAX_PATTERN_BYTES; b++) begin
      j    = len_c - LEN_W'(1) - LEN_W'(b);
      seen = (b == 0) ? cur_byte : window[(b == 0) ? 0 : b - 1];
      mismatch[b] = (LEN_W'(b) < len_c) && cfg.care[j[FILL_W-1:0]] &&
                    (seen != cfg.bytes[j[FILL_W-1:0]]);
    end
  end

  assign result.hit    = (len_c != '0) && enough && (mismatch == '0);
  assign result.offset = FILL_W'(len_c - LEN_W'(1));

endmodule

### rtl/core/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// Wildcard byte pattern search. Takes one memory byte per cycle with its address and
// reports the address of the first place where the configured pattern (up to 16 bytes,
// care_mask clear = wildcard) matches, or a no-match result on the scan's last byte.
// Input tlast marks the scan's last byte, input tuser the last byte of a region; a
// match never spans regions. An item is accepted every cycle while the result side
// keeps up. A byte waits in the input register while all pattern positions are
// compared in parallel, and the outcome is caught in the result register, from which
// the result is offered. After a match, bytes up to the end of the scan give no result.
// Configuration must be written only while idle; the block itself does not enforce it.
module masked_byte_pattern_scanner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mbps_pkg::IN_TDATA_W-1:0]     in_tdata,   // data_byte, byte_address
  input  logic                                in_tuser,   // region_end
  input  logic                                in_tlast,   // scan_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mbps_pkg::OUT_TDATA_W-1:0]    out_tdata,  // match_address
  output logic                                out_tuser   // found
);
  import mbps_pkg::*;

  mbps_cfg_t cfg_r;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_region_end_r;
  logic              s1_scan_end_r;

  mbps_win_t         window_r, window_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              done_r, done_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic      advance;
  logic      in_fire;
  logic      res_valid;
  mbps_hit_t hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: cfg_r.length <= cfg_data[LEN_W-1:0];
        REG_PATTERN_LOW:    cfg_r.bytes[7:0] <= cfg_data;
        REG_PATTERN_HIGH:   cfg_r.bytes[15:8] <= cfg_data;
        REG_CARE_MASK:      cfg_r.care <= cfg_data[MAX_PATTERN_BYTES-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r       <= in_tdata[BYTE_W-1:0];
      s1_addr_r       <= in_tdata[BYTE_W +: ADDR_W];
      s1_region_end_r <= in_tuser;
      s1_scan_end_r   <= in_tlast;
    end
  end

  mbps_match u_match (
    .cfg      (cfg_r),
    .cur_byte (s1_byte_r),
    .window   (window_r),
    .fill     (fill_r),
    .result   (hit)
  );

  always_comb begin
    window_nxt    = window_r;
    fill_nxt      = fill_r;
    done_nxt      = done_r;
    res_valid     = 1'b0;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (advance) begin
      if (done_r) begin
        // swallow bytes until the scan closes
        if (s1_scan_end_r) begin
          done_nxt = 1'b0;
          fill_nxt = '0;
        end
      end else begin
        window_nxt = {window_r[WIN_DEPTH-2:0], s1_byte_r};
        if (fill_r != FILL_W'(WIN_DEPTH)) fill_nxt = fill_r + FILL_W'(1);
        if (s1_region_end_r || s1_scan_end_r) fill_nxt = '0;
        if (hit.hit) begin
          res_valid     = 1'b1;
          out_found_nxt = 1'b1;
          out_addr_nxt  = s1_addr_r - ADDR_W'(hit.offset);
          done_nxt      = !s1_scan_end_r;
        end else if (s1_scan_end_r) begin
          res_valid     = 1'b1;
          out_found_nxt = 1'b0;
          out_addr_nxt  = '0;
        end
      end
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window bytes beyond the fill count are never compared
  always_ff @(posedge clk) begin
    window_r    <= window_nxt;
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_addr_r;

endmodule

### rtl/core/mbps_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbps_port_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [mbps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                                out_tuser
);
  import mbps_pkg::*;

  // a held result keeps its payload
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result dropped or changed while stalled")

  // a scan without a match reports address zero
  `CHK_ASSERT(a_nomatch_zero, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata == '0, "no-match item carries a nonzero address")

  // nothing is offered in the cycle after reset
  `CHK_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "result valid straight after reset")

endmodule

bind masked_byte_pattern_scanner mbps_port_checker u_mbps_port_checker (.*);

### verif/mbps_checker.sv
`timescale 1ns / 1ps
module mbps_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [mbps_pkg::IN_TDATA_W-1:0]    in_tdata,   // data_byte, byte_address
  input  logic                               in_tuser,   // region_end
  input  logic                               in_tlast,   // scan_end
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [mbps_pkg::OUT_TDATA_W-1:0]   out_tdata,  // match_address
  input  logic                               out_tuser,  // found
  output int                                 n_errors,
  output int                                 pending,
  output int                                 n_scanned,
  output int                                 n_hits,
  output int                                 n_misses
);
  import mbps_pkg::*;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_result_t;

  scan_result_t                 result_q[$];
  logic [LEN_W-1:0]             pat_len;
  mbps_pat_t                    pat;
  logic [MAX_PATTERN_BYTES-1:0] care;
  // hist[k] holds the byte k+1 positions before the current one
  logic [BYTE_W-1:0]            hist [WIN_DEPTH];
  int                           hist_fill;
  logic                         after_hit;
  int                           errs;
  int                           scanned;
  int                           hits;
  int                           misses;

  initial begin
    n_errors  = 0;
    pending   = 0;
    n_scanned = 0;
    n_hits    = 0;
    n_misses  = 0;
    errs      = 0;
    scanned   = 0;
    hits      = 0;
    misses    = 0;
  end

  task automatic clear_hist();
    for (int k = 0; k < WIN_DEPTH; k++) hist[k] = '0;
    hist_fill = 0;
  endtask

  task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic [ADDR_W-1:0] a,
                           input logic reg_end, input logic scn_end);
    int                eff;
    int                back;
    logic [BYTE_W-1:0] seen;
    logic              hit;
    scan_result_t      exp_res;
    scanned++;
    if (after_hit) begin
      // rest of the scan is skipped; its last byte re-arms
      if (scn_end) begin
        after_hit = 1'b0;
        clear_hist();
      end
      return;
    end
    eff = (pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len);
    hit = (eff != 0) && (hist_fill + 1 >= eff);
    for (int j = 0; j < eff; j++) begin
      back = eff - 1 - j;
      seen = (back == 0) ? b : hist[back-1];
      if (care[j] && seen != pat[j]) hit = 1'b0;
    end
    for (int k = WIN_DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = b;
    if (hist_fill < WIN_DEPTH) hist_fill++;
    if (reg_end || scn_end) clear_hist();
    if (hit) begin
      exp_res = '{found: 1'b1, addr: a - ADDR_W'(eff - 1)};
      result_q.insert(result_q.size(), exp_res);
      if (!scn_end) after_hit = 1'b1;
    end else if (scn_end) begin
      exp_res = '{found: 1'b0, addr: '0};
      result_q.insert(result_q.size(), exp_res);
    end
  endtask

  task automatic check_result(input logic f, input logic [ADDR_W-1:0] a);
    scan_result_t want;
    if (f) hits++;
    else misses++;
    if (result_q.size() == 0) begin
      errs++;
      if (errs <= 10) $display("unexpected result: found=%0b addr=%h", f, a);
      return;
    end
    want = result_q.pop_front();
    if (want.found !== f || want.addr !== a) begin
      errs++;
      if (errs <= 10)
        $display("result mismatch: expected found=%0b addr=%h, got found=%0b addr=%h",
                 want.found, want.addr, f, a);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      result_q.delete();
      pat_len   = '0;
      pat       = '0;
      care      = '0;
      after_hit = 1'b0;
      clear_hist();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
          REG_PATTERN_LOW:    pat[7:0] = cfg_data;
          REG_PATTERN_HIGH:   pat[15:8] = cfg_data;
          REG_CARE_MASK:      care = cfg_data[MAX_PATTERN_BYTES-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        scan_byte(in_tdata[BYTE_W-1:0], in_tdata[BYTE_W +: ADDR_W], in_tuser, in_tlast);
      if (out_tvalid && out_tready)
        check_result(out_tuser, out_tdata);
    end
    // mirrored with NBAs so the stimulus side reads settled values
    n_errors  <= errs;
    pending   <= result_q.size();
    n_scanned <= scanned;
    n_hits    <= hits;
    n_misses  <= misses;
  end

endmodule

### verif/tb_masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
module tb_masked_byte_pattern_scanner;
  import mbps_pkg::*;

  localparam int RUN_ITEMS    = 1800;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int SETTLE       = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int N_SETTINGS   = 12;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // data_byte, byte_address
  logic                   in_tuser   = 1'b0; // region_end
  logic                   in_tlast   = 1'b0; // scan_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // match_address
  logic                   out_tuser;         // found

  int n_errors, pending, n_scanned, n_hits, n_misses;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  logic hold_req   = 1'b0;
  logic hold_off   = 1'b0;
  int cycles       = 0;
  int in_stalls    = 0;

  // pattern currently loaded, used to plant matches
  int           cur_len  = 0;
  logic [127:0] cur_pat  = '0;
  logic [15:0]  cur_care = '0;

  masked_byte_pattern_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mbps_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .n_errors   (n_errors),
    .pending    (pending),
    .n_scanned  (n_scanned),
    .n_hits     (n_hits),
    .n_misses   (n_misses)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= !hold_off && ($urandom_range(99) >= out_idle_pct);
    if (in_tvalid && !in_tready) in_stalls <= in_stalls + 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_masked_byte_pattern_scanner: errors");
      $finish;
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin
    wait (hold_req);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [ADDR_W-1:0] a;
    a = {16'($urandom), 32'($urandom)};
    case ($urandom_range(7))
      0: a = ADDR_W'($urandom_range(20));
      1: a = '1 - ADDR_W'($urandom_range(20));
      default: ;
    endcase
    return a;
  endfunction

  // ready is sampled mid-cycle, where it is steady, to know whether the next edge takes the item
  task automatic send_item(input logic [7:0] b, input logic [ADDR_W-1:0] a,
                           input logic reg_end, input logic scn_end);
    bit taken;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {a, b};
    in_tuser  <= reg_end;
    in_tlast  <= scn_end;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input mbps_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_pattern(input int len, input logic [127:0] bytes,
                              input logic [15:0] mask);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_PATTERN_LOW, bytes[63:0]);
    write_reg(REG_PATTERN_HIGH, bytes[127:64]);
    write_reg(REG_CARE_MASK, CFG_DATA_W'(mask));
    cfg_valid <= 1'b0;
    cur_len  = len;
    cur_pat  = bytes;
    cur_care = mask;
  endtask

  // one scan: random bytes biased towards pattern bytes, usually with the
  // pattern planted somewhere, sometimes broken by a flipped bit
  task automatic run_scan(input int longest);
    int                n;
    int                eff;
    int                at;
    logic [7:0]        scan_bytes[];
    logic [ADDR_W-1:0] a;
    logic              reg_end;
    logic              is_last;
    n = ($urandom_range(9) == 0) ? $urandom_range(longest, 2 * longest)
                                 : $urandom_range(1, longest);
    scan_bytes = new[n];
    for (int i = 0; i < n; i++)
      scan_bytes[i] = $urandom_range(1) ? cur_pat[8 * $urandom_range(15) +: 8]
                                        : 8'($urandom);
    eff = (cur_len > 16) ? 16 : cur_len;
    if (eff > 0 && eff <= n && $urandom_range(9) < 7) begin
      at = $urandom_range(n - eff);
      for (int j = 0; j < eff; j++)
        if (cur_care[j]) scan_bytes[at + j] = cur_pat[8 * j +: 8];
      if ($urandom_range(3) == 0)
        scan_bytes[at + $urandom_range(eff - 1)] ^= 8'(1 << $urandom_range(7));
    end
    a = pick_addr();
    for (int i = 0; i < n; i++) begin
      is_last = (i == n - 1);
      reg_end = ($urandom_range(15) == 0) || (is_last && $urandom_range(1));
      send_item(scan_bytes[i], a, reg_end, is_last);
      a = a + 1'b1;
      if (reg_end || $urandom_range(40) == 0) a = pick_addr();
    end
  endtask

  initial begin
    int           base;
    int           goal;
    int           len;
    logic [15:0]  mask;
    logic [127:0] bytes;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pattern straight out of reset: end of scan gives no match
    send_item(8'h00, 48'h0, 1'b0, 1'b0);
    send_item(8'hFF, 48'h1, 1'b1, 1'b0);
    send_item(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1);

    load_pattern(4, {64'h0123_4567_89AB_CDEF, 64'h0000_0000_EFBE_ADDE}, 16'h000F);
    // pattern split by a region end must not match
    send_item(8'hDE, 48'h100, 1'b0, 1'b0);
    send_item(8'hAD, 48'h101, 1'b1, 1'b0);
    send_item(8'hBE, 48'h102, 1'b0, 1'b0);
    send_item(8'hEF, 48'h103, 1'b0, 1'b1);
    // match on the scan's last byte, address wraps through zero
    send_item(8'hDE, 48'hFFFF_FFFF_FFFE, 1'b0, 1'b0);
    send_item(8'hAD, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_item(8'hBE, 48'h0, 1'b0, 1'b0);
    send_item(8'hEF, 48'h1, 1'b0, 1'b1);
    // bytes after a match are skipped up to the end of the scan
    send_item(8'h55, 48'h200, 1'b0, 1'b0);
    send_item(8'hDE, 48'h201, 1'b0, 1'b0);
    send_item(8'hAD, 48'h202, 1'b0, 1'b0);
    send_item(8'hBE, 48'h203, 1'b0, 1'b0);
    send_item(8'hEF, 48'h204, 1'b0, 1'b0);
    send_item(8'h00, 48'h205, 1'b0, 1'b0);
    send_item(8'hFF, 48'h206, 1'b1, 1'b0);
    send_item(8'hDE, 48'h207, 1'b0, 1'b1);

    // all care bits clear, addresses not contiguous
    load_pattern(3, {$urandom, $urandom, $urandom, $urandom}, 16'h0000);
    send_item(8'h11, 48'h10, 1'b1, 1'b0);
    send_item(8'h33, 48'h10, 1'b0, 1'b0);
    send_item(8'h44, 48'h500, 1'b0, 1'b0);
    send_item(8'h55, 48'h20, 1'b0, 1'b1);

    base = n_scanned;
    for (int k = 0; k < N_SETTINGS; k++) begin
      if (k == 0) begin
        in_idle_pct = 13;
        out_idle_pct <= 70;
      end else if (k == N_SETTINGS / 3) begin
        in_idle_pct = 70;
        out_idle_pct <= 13;
      end else if (k == 2 * N_SETTINGS / 3) begin
        in_idle_pct = 0;
        out_idle_pct <= 0;
      end
      bytes = {$urandom, $urandom, $urandom, $urandom};
      mask  = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom);
      len   = ($urandom_range(3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      case (k)
        0: mask = 16'hFFFF;
        1: len = 31;
        2: begin
          len  = 1;
          mask = 16'h0001;
        end
        3: len = 0;
        4: mask = 16'h0000;
        5: begin
          len   = 16;
          bytes = '1;
          mask  = 16'hFFFF;
        end
        6: begin
          len   = 16;
          bytes = '0;
          mask  = 16'hFFFF;
        end
        7: len = 17 + $urandom_range(13);
        default: ;
      endcase
      if (k == 0) len = 16;
      load_pattern(len, bytes, mask);
      goal = base + (RUN_ITEMS * (k + 1)) / N_SETTINGS;
      while (n_scanned < goal) run_scan(30);
    end

    // short scans against a stalled receiver
    load_pattern(2, {$urandom, $urandom, $urandom, $urandom}, 16'($urandom));
    hold_req <= 1'b1;
    repeat (80) run_scan(2);

    wait_idle();
    $display("%0d bytes scanned over %0d pattern settings plus directed cases", n_scanned,
             N_SETTINGS + 3);
    $display("%0d matches, %0d scans without one, input stalled %0d cycles",
             n_hits, n_misses, in_stalls);
    if (n_errors == 0 && pending == 0) begin
      $display("tb_masked_byte_pattern_scanner: clean");
    end else begin
      $display("tb_masked_byte_pattern_scanner: errors");
    end
    $finish;
  end

endmodule
